/* hw/rtl/mipmap_box_downsample_unit_defines.svh */
// Assertion macros shared by the mipmap box downsample RTL.
`ifndef MIPMAP_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mbd_pkg.sv */
// Types and constants shared by the mipmap box downsample unit.
package mbd_pkg;

  localparam int MAX_SIZE_LOG2 = 11;
  localparam int CNT_W         = MAX_SIZE_LOG2;
  localparam int LINE_AW       = MAX_SIZE_LOG2 - 1;
  localparam int LINE_DEPTH    = 1 << LINE_AW;
  localparam int CFG_W         = 4;
  localparam int SUM_W         = 9;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [LINE_AW-1:0] slot_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic [7:0] src_alpha;
    logic [7:0] src_blue;
    logic [7:0] src_green;
    logic [7:0] src_red;
  } src_pixel_t;

  typedef struct packed {
    logic       last_of_level;
    logic [7:0] dst_alpha;
    logic [7:0] dst_blue;
    logic [7:0] dst_green;
    logic [7:0] dst_red;
  } dst_pixel_t;

  // One line buffer entry: horizontal pair sums of an even row plus top-left alpha.
  typedef struct packed {
    logic [7:0] alpha;
    sum_t       sum_blue;
    sum_t       sum_green;
    sum_t       sum_red;
  } line_entry_t;

  // Where the pixel being accepted sits in the source level.
  typedef struct packed {
    logic  col_odd;
    logic  row_odd;
    slot_t slot;
    logic  last_pixel;
  } pos_t;

endpackage

/* hw/rtl/mbd_position.sv */
// Column and row counters of the source level, with the configured size.
module mbd_position (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mbd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       advance_i,
  output mbd_pkg::pos_t              pos_o
);
  import mbd_pkg::*;

  cnt_t              col_q, col_d;
  cnt_t              row_q, row_d;
  cnt_t              last_idx_q, last_idx_d;
  logic [CFG_W-1:0]  size_lg;
  logic [CNT_W:0]    side_full;
  logic              col_end;
  logic              row_end;

  // Out-of-range sizes are clamped to the supported range.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      size_lg = CFG_W'(1);
    end else if (cfg_wdata_i > CFG_W'(MAX_SIZE_LOG2)) begin
      size_lg = CFG_W'(MAX_SIZE_LOG2);
    end else begin
      size_lg = cfg_wdata_i;
    end
    side_full  = ({{CNT_W{1'b0}}, 1'b1} << size_lg) - {{CNT_W{1'b0}}, 1'b1};
    last_idx_d = side_full[CNT_W-1:0];
  end

  assign col_end = (col_q >= last_idx_q);
  assign row_end = (row_q >= last_idx_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      last_idx_q <= '1;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        last_idx_q <= last_idx_d;
      end
    end
  end

  assign pos_o.col_odd    = col_q[0];
  assign pos_o.row_odd    = row_q[0];
  assign pos_o.slot       = col_q[CNT_W-1:1];
  assign pos_o.last_pixel = col_end && row_end;

endmodule

/* hw/rtl/mbd_line_buf.sv */
// Line buffer of even-row pair sums, one write and one registered read port.
module mbd_line_buf (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  mbd_pkg::slot_t        waddr_i,
  input  mbd_pkg::line_entry_t  wdata_i,
  input  logic                  re_i,
  input  mbd_pkg::slot_t        raddr_i,
  output mbd_pkg::line_entry_t  rdata_o
);
  import mbd_pkg::*;

  line_entry_t mem_q [LINE_DEPTH];
  line_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/mipmap_box_downsample_unit.sv */
// Top level of the 2x2 box-filter mipmap downsampler.
`include "mipmap_box_downsample_unit_defines.svh"

// Source pixels of one square level are taken in raster order, one per cycle with no
// gaps needed between them; every odd column of an odd row completes a 2x2 block and
// its result is registered in stage one and then in the output register.
// The rate of one pixel per cycle is set by the work per pixel, one add and at most one
// access to the line buffer of 1024 x 35 bits, which has one write and one read port,
// is written on even rows and read on odd rows, and needs no clearing after reset.
// The input stalls only while a completed block waits in stage one behind a stalled
// result. Writing the size register restarts the level at its top-left pixel and
// must only happen while the block is idle.
module mipmap_box_downsample_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mbd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mbd_pkg::src_pixel_t        in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mbd_pkg::dst_pixel_t        out_data_o
);
  import mbd_pkg::*;

  pos_t        pos;
  logic        in_accept;
  logic        out_free;
  logic        s1_adv;
  logic        line_we;
  logic        line_re;
  src_pixel_t  hold_q;
  line_entry_t pair;
  line_entry_t top;
  logic        s1_valid_q;
  sum_t        s1_red_q, s1_green_q, s1_blue_q;
  logic        s1_last_q;
  logic        out_valid_q;
  dst_pixel_t  out_q;
  logic [SUM_W:0] tot_red, tot_green, tot_blue;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  mbd_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (in_accept),
    .pos_o       (pos)
  );

  // Horizontal pair of the held even-column pixel and the current odd-column one.
  assign pair.sum_red   = {1'b0, hold_q.src_red}   + {1'b0, in_data_i.src_red};
  assign pair.sum_green = {1'b0, hold_q.src_green} + {1'b0, in_data_i.src_green};
  assign pair.sum_blue  = {1'b0, hold_q.src_blue}  + {1'b0, in_data_i.src_blue};
  assign pair.alpha     = hold_q.src_alpha;

  assign line_we = in_accept && pos.col_odd && !pos.row_odd;
  assign line_re = in_accept && pos.col_odd && pos.row_odd;

  mbd_line_buf u_line_buf (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (pos.slot),
    .wdata_i (pair),
    .re_i    (line_re),
    .raddr_i (pos.slot),
    .rdata_o (top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (cfg_we_i) begin
      hold_q <= '0;
    end else if (in_accept && !pos.col_odd) begin
      hold_q <= in_data_i;
    end
  end

  // Stage one: bottom pair sums wait here while the top pair is read from the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (line_re) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      s1_red_q   <= pair.sum_red;
      s1_green_q <= pair.sum_green;
      s1_blue_q  <= pair.sum_blue;
      s1_last_q  <= pos.last_pixel;
    end
  end

  assign tot_red   = {1'b0, top.sum_red}   + {1'b0, s1_red_q};
  assign tot_green = {1'b0, top.sum_green} + {1'b0, s1_green_q};
  assign tot_blue  = {1'b0, top.sum_blue}  + {1'b0, s1_blue_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.dst_red       <= tot_red[SUM_W:2];
      out_q.dst_green     <= tot_green[SUM_W:2];
      out_q.dst_blue      <= tot_blue[SUM_W:2];
      out_q.dst_alpha     <= top.alpha;
      out_q.last_of_level <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MBD_ASSERT_IMPLIES(a_stall_when_full, clk_i, rst_ni,
                      s1_valid_q && out_valid_q && out_stall_i, in_stall_o,
                      "input taken while both result stages are blocked")
  `MBD_ASSERT_NEXT(a_block_completes, clk_i, rst_ni, line_re, s1_valid_q,
                   "completed block did not enter stage one")
  `MBD_ASSERT_NEXT(a_cfg_restarts, clk_i, rst_ni, cfg_we_i,
                   !pos.col_odd && !pos.row_odd && pos.slot == '0,
                   "size write did not restart the level")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the 2x2 box-filter mipmap downsampler.
module tb;
  import mbd_pkg::*;

  localparam int          HALF_PERIOD   = 10;
  localparam int          RESET_CYCLES  = 12;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          MAX_WAIT      = 11;
  localparam int          RANDOM_PIXELS = 400;
  localparam int          WIDE_LOG2     = 8;

  logic             clk_i     = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  src_pixel_t       in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  dst_pixel_t       out_data;

  mipmap_box_downsample_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Predictor state, mirroring the block's own.
  logic [CFG_W-1:0] size_reg = CFG_W'(MAX_SIZE_LOG2);
  cnt_t             col_pos  = '0;
  cnt_t             row_pos  = '0;
  src_pixel_t       left_hold = '0;
  line_entry_t      line_sums [LINE_DEPTH];

  src_pixel_t  pending_pixels[$];
  dst_pixel_t  expected_dst[$];
  int unsigned pixels_pushed   = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;
  bit          src_fire        = 1'b0;
  bit          src_calm        = 1'b0;
  bit          dst_calm        = 1'b0;
  int unsigned src_gap         = 0;
  int unsigned dst_hold        = 0;

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Works out the result, if any, that one source pixel completes.
  function automatic bit predict_downsample(input src_pixel_t px, output dst_pixel_t res);
    int unsigned    side;
    cnt_t           last_idx;
    slot_t          slot;
    sum_t           s_red, s_green, s_blue;
    line_entry_t    top;
    logic [SUM_W:0] t_red, t_green, t_blue;
    bit             made;
    side = (size_reg < 1) ? 1 : ((size_reg > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : size_reg);
    last_idx = cnt_t'((1 << side) - 1);
    slot = slot_t'(col_pos >> 1);
    made = 1'b0;
    res = '0;
    if (!col_pos[0]) begin
      left_hold = px;
    end else begin
      s_red   = sum_t'(left_hold.src_red)   + sum_t'(px.src_red);
      s_green = sum_t'(left_hold.src_green) + sum_t'(px.src_green);
      s_blue  = sum_t'(left_hold.src_blue)  + sum_t'(px.src_blue);
      if (!row_pos[0]) begin
        line_sums[slot] = {left_hold.src_alpha, s_blue, s_green, s_red};
      end else begin
        top     = line_sums[slot];
        t_red   = {1'b0, top.sum_red}   + {1'b0, s_red};
        t_green = {1'b0, top.sum_green} + {1'b0, s_green};
        t_blue  = {1'b0, top.sum_blue}  + {1'b0, s_blue};
        res.dst_red       = t_red[SUM_W:2];
        res.dst_green     = t_green[SUM_W:2];
        res.dst_blue      = t_blue[SUM_W:2];
        res.dst_alpha     = top.alpha;
        res.last_of_level = (col_pos == last_idx) && (row_pos == last_idx);
        made = 1'b1;
      end
    end
    if (col_pos >= last_idx) begin
      col_pos = '0;
      row_pos = (row_pos >= last_idx) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return made;
  endfunction

  // Monitor: tracks accepted transactions on both channels and register writes.
  always @(posedge clk_i) begin
    dst_pixel_t want;
    dst_pixel_t res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** mipmap_box_downsample_unit: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) begin
        size_reg  = cfg_wdata;
        col_pos   = '0;
        row_pos   = '0;
        left_hold = '0;
      end
      src_fire = in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        pixels_accepted++;
        if (predict_downsample(in_data, res)) expected_dst.push_back(res);
      end
      if (out_valid && !out_stall) begin
        dst_hold = draw_wait(dst_calm);
        if (expected_dst.size() == 0) begin
          $error("unexpected output transaction: %h", out_data);
          mismatches++;
        end else begin
          want = expected_dst.pop_front();
          if (out_data.dst_red !== want.dst_red) begin
            $error("dst_red: expected %0d, got %0d", want.dst_red, out_data.dst_red);
            mismatches++;
          end
          if (out_data.dst_green !== want.dst_green) begin
            $error("dst_green: expected %0d, got %0d", want.dst_green, out_data.dst_green);
            mismatches++;
          end
          if (out_data.dst_blue !== want.dst_blue) begin
            $error("dst_blue: expected %0d, got %0d", want.dst_blue, out_data.dst_blue);
            mismatches++;
          end
          if (out_data.dst_alpha !== want.dst_alpha) begin
            $error("dst_alpha: expected %0d, got %0d", want.dst_alpha, out_data.dst_alpha);
            mismatches++;
          end
          if (out_data.last_of_level !== want.last_of_level) begin
            $error("last_of_level: expected %0d, got %0d", want.last_of_level,
                   out_data.last_of_level);
            mismatches++;
          end
        end
      end
    end
  end

  // Source driver: holds each pixel until its transaction completes, then waits its gap.
  always @(negedge clk_i) begin
    if (rst_n && !(in_valid && !src_fire)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_data  <= pending_pixels.pop_front();
        in_valid <= 1'b1;
        src_gap = draw_wait(src_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: after each accepted result the next one is held back for a drawn time.
  always @(negedge clk_i) begin
    if (dst_hold > 0) begin
      out_stall <= 1'b1;
      if (out_valid) dst_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] random_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_pixel(input src_pixel_t px);
    pending_pixels.push_back(px);
    pixels_pushed++;
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) push_pixel({random_channel(), random_channel(), random_channel(),
                               random_channel()});
  endtask

  task automatic wait_drained();
    while (pixels_accepted != pixels_pushed || expected_dst.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Registers are only written once every transaction has gone through.
  task automatic start_level(input int unsigned size_value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(size_value);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    src_calm = ($urandom_range(0, 3) == 0);
    dst_calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int unsigned sz;
    int unsigned side;
    int unsigned count;
    int unsigned random_total;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_n = 1'b1;

    // Reset size is the largest level; only part of its first row is sent.
    push_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    push_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    push_pixel({8'h80, 8'h7F, 8'h01, 8'hFE});
    push_random(3);

    // A size of zero is taken as the smallest level, 2x2.
    start_level(0);
    repeat (4) push_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    repeat (4) push_pixel({8'h00, 8'h00, 8'h00, 8'h00});
    // Truncation of the mean, and alpha taken from the top-left pixel only.
    push_pixel({8'h5A, 8'h03, 8'hFE, 8'h01});
    push_pixel({8'hFF, 8'h00, 8'hFF, 8'h01});
    push_pixel({8'h00, 8'h00, 8'hFF, 8'h01});
    push_pixel({8'h00, 8'h00, 8'hFF, 8'h00});
    start_level(1);
    push_random(4);

    // Every other register value, with a short first row only.
    for (sz = 2; sz <= 15; sz++) begin
      if (sz == MAX_SIZE_LOG2) continue;
      side = 1 << ((sz > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : sz);
      start_level(sz);
      push_random($urandom_range(1, (side > 40) ? 40 : side));
    end

    // Two full rows of a wide level, so that a whole row of sums is read back.
    start_level(WIDE_LOG2);
    push_random(2 * (1 << WIDE_LOG2) + $urandom_range(1, 8));

    random_total = 0;
    while (random_total < RANDOM_PIXELS) begin
      sz   = $urandom_range(1, 5);
      side = 1 << sz;
      if (sz <= 4 && $urandom_range(0, 1) == 1)
        count = side * side * ((sz <= 3) ? $urandom_range(1, 4) : 1);
      else
        count = side * $urandom_range(2, 6) + $urandom_range(0, side - 1);
      start_level(sz);
      if ($urandom_range(0, 3) == 0) begin
        // The sender stops mid-level until every result has been taken.
        push_random(count / 2);
        wait_drained();
        push_random(count - count / 2);
      end else begin
        push_random(count);
      end
      random_total += count;
    end

    wait_drained();
    if (mismatches == 0 && expected_dst.size() == 0) begin
      $display("** mipmap_box_downsample_unit: PASSED **");
    end else begin
      $display("** mipmap_box_downsample_unit: FAILED **");
    end
    $finish;
  end

endmodule
